// File: rtl/core/tcws_pkg.sv
package tcws_pkg;

  // field widths fixed by the interface
  localparam int unsigned STATE_W = 6;
  localparam int unsigned RND_W   = 31;
  localparam int unsigned DIV_CW  = $clog2(RND_W);

  // default sizing
  localparam int unsigned DefNumStates    = 64;
  localparam int unsigned DefMaxSuccessors = 16;
  localparam int unsigned DefCountWidth   = 16;

  // operation codes
  localparam logic FUNC_RECORD = 1'b0;
  localparam logic FUNC_SAMPLE = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic               func;
    logic [STATE_W-1:0] from_state;
    logic [STATE_W-1:0] to_state;
    logic [RND_W-1:0]   random_value;
  } in_t;

  typedef struct packed {
    status_e            status;
    logic [STATE_W-1:0] next_state;
  } out_t;

endpackage

// File: rtl/core/transition_count_weighted_sampler.sv
// Markov transition recorder and roulette-wheel sampler. Every state keeps up to
// MAX_SUCCESSORS (successor id, count) entries in a synchronous entry memory with
// one read and one write port, and its list length in a second memory. A record
// transfer walks the list one entry per cycle and bumps the matching count
// (saturating) or appends a new entry. A sample transfer walks the list to sum the
// counts, reduces random_value modulo that sum in a bit-serial restoring divider,
// then walks the list again until the running total passes the reduced value. The
// registered memory read is hidden by streaming reads one entry ahead of the walk.
// One item is in work at a time; the next input is taken as soon as the result
// sits in the output register, even if the consumer still stalls it. After reset
// the block clears all NUM_STATES entries of the length memory and stalls its
// input meanwhile. A from_state at or above NUM_STATES wraps modulo NUM_STATES.
module transition_count_weighted_sampler
  import tcws_pkg::*;
#(
  parameter int unsigned NUM_STATES     = DefNumStates,
  parameter int unsigned MAX_SUCCESSORS = DefMaxSuccessors,
  parameter int unsigned COUNT_WIDTH    = DefCountWidth
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_o
);

  localparam int unsigned SW   = $clog2(NUM_STATES);
  localparam int unsigned LW   = $clog2(MAX_SUCCESSORS + 1);
  localparam int unsigned AW   = $clog2(NUM_STATES * MAX_SUCCESSORS);
  localparam int unsigned SUMW = COUNT_WIDTH + $clog2(MAX_SUCCESSORS);
  localparam int unsigned ENTRIES = NUM_STATES * MAX_SUCCESSORS;

  typedef struct packed {
    logic [STATE_W-1:0]     id;
    logic [COUNT_WIDTH-1:0] cnt;
  } entry_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LEN,
    ST_WALK,
    ST_SUM,
    ST_DIV,
    ST_PICK,
    ST_DONE
  } state_e;

  // from_state modulo NUM_STATES by shifted compare and subtract
  function automatic logic [SW-1:0] wrap_state(input logic [STATE_W-1:0] raw);
    int unsigned r;
    r = 32'(raw);
    for (int k = STATE_W - 1; k >= 0; k--) begin
      if (r >= (32'(NUM_STATES) << k)) begin
        r = r - (32'(NUM_STATES) << k);
      end
    end
    return SW'(r);
  endfunction

  // ---------------------------------------------------------------------------
  // memories: list lengths and successor entries, read data registered
  // ---------------------------------------------------------------------------
  logic [LW-1:0] len_mem [NUM_STATES];
  entry_t        ent_mem [ENTRIES];

  logic          len_we, len_re;
  logic [SW-1:0] len_wa, len_ra;
  logic [LW-1:0] len_wd, len_rd_q;

  logic          ent_we, ent_re;
  logic [AW-1:0] ent_wa, ent_ra;
  entry_t        ent_wd, ent_rd_q;

  always_ff @(posedge clk_i) begin
    if (len_we) begin
      len_mem[len_wa] <= len_wd;
    end
    if (len_re) begin
      len_rd_q <= len_mem[len_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ent_we) begin
      ent_mem[ent_wa] <= ent_wd;
    end
    if (ent_re) begin
      ent_rd_q <= ent_mem[ent_ra];
    end
  end

  // ---------------------------------------------------------------------------
  // sequencer registers
  // ---------------------------------------------------------------------------
  state_e             state_q;
  logic [SW-1:0]      clr_q;
  logic               func_q;
  logic [SW-1:0]      from_q;
  logic [STATE_W-1:0] to_q;
  logic [RND_W-1:0]   rnd_q;
  logic [AW-1:0]      base_q;
  logic [LW-1:0]      len_q;
  logic [LW-1:0]      chk_q;
  logic [SUMW-1:0]    acc_q;
  logic [SUMW-1:0]    sum_q;
  logic [SUMW-1:0]    rem_q;
  logic [DIV_CW-1:0]  div_cnt_q;
  status_e            res_status_q;
  logic [STATE_W-1:0] res_next_q;
  logic               out_valid_q;
  out_t               out_q;

  logic               in_xfer;
  logic [SW-1:0]      in_idx;
  logic [LW-1:0]      chk_nx;
  logic               walk_last;
  logic               walk_hit;
  logic [SUMW-1:0]    acc_nx;
  logic [SUMW:0]      rem_sh;
  logic [SUMW:0]      sum_ext;
  logic               div_last;
  logic               append_now;
  logic [LW-1:0]      append_pos;
  logic [COUNT_WIDTH-1:0] cnt_inc;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign in_idx     = wrap_state(in_i.from_state);

  assign chk_nx     = chk_q + 1'b1;
  assign walk_last  = (chk_nx == len_q);
  assign walk_hit   = (ent_rd_q.id == to_q);
  assign acc_nx     = acc_q + SUMW'(ent_rd_q.cnt);

  // one restoring division step: shift in the next draw bit, subtract if it fits
  assign rem_sh     = {rem_q, rnd_q[RND_W-1]};
  assign sum_ext    = {1'b0, sum_q};
  assign div_last   = (div_cnt_q == DIV_CW'(RND_W - 1));

  assign cnt_inc    = (&ent_rd_q.cnt) ? ent_rd_q.cnt : ent_rd_q.cnt + 1'b1;

  // new successor goes to the end of the list: empty list seen at length
  // lookup, or a full walk that found no match and still has room
  always_comb begin
    append_now = 1'b0;
    append_pos = len_q;
    if (state_q == ST_LEN && func_q == FUNC_RECORD && len_rd_q == '0) begin
      append_now = 1'b1;
      append_pos = '0;
    end else if (state_q == ST_WALK && !walk_hit && walk_last &&
                 len_q < LW'(MAX_SUCCESSORS)) begin
      append_now = 1'b1;
      append_pos = len_q;
    end
  end

  // memory port control
  always_comb begin
    len_re = in_xfer;
    len_ra = in_idx;
    len_we = 1'b0;
    len_wa = from_q;
    len_wd = append_pos + 1'b1;
    if (state_q == ST_CLEAR) begin
      len_we = 1'b1;
      len_wa = clr_q;
      len_wd = '0;
    end else if (append_now) begin
      len_we = 1'b1;
    end

    // reads run one entry ahead of the entry being looked at
    ent_re = 1'b0;
    ent_ra = base_q + AW'(chk_nx);
    case (state_q)
      ST_LEN: begin
        ent_re = (len_rd_q != '0);
        ent_ra = base_q;
      end
      ST_WALK, ST_SUM, ST_PICK: begin
        ent_re = !walk_last;
      end
      ST_DIV: begin
        ent_re = div_last;
        ent_ra = base_q;
      end
      default: begin
        ent_re = 1'b0;
      end
    endcase

    ent_we = append_now;
    ent_wa = base_q + AW'(append_pos);
    ent_wd.id  = to_q;
    ent_wd.cnt = COUNT_WIDTH'(1);
    if (state_q == ST_WALK && walk_hit) begin
      ent_we     = 1'b1;
      ent_wa     = base_q + AW'(chk_q);
      ent_wd.id  = ent_rd_q.id;
      ent_wd.cnt = cnt_inc;
    end
  end

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      clr_q        <= '0;
      func_q       <= FUNC_RECORD;
      from_q       <= '0;
      to_q         <= '0;
      rnd_q        <= '0;
      base_q       <= '0;
      len_q        <= '0;
      chk_q        <= '0;
      acc_q        <= '0;
      sum_q        <= '0;
      rem_q        <= '0;
      div_cnt_q    <= '0;
      res_status_q <= STATUS_OK;
      res_next_q   <= '0;
      out_valid_q  <= 1'b0;
      out_q        <= '0;
    end else begin
      // output register drains on its own; a load in ST_DONE takes precedence
      if (out_valid_q && !out_stall_i && state_q != ST_DONE) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        // length memory clearing pass after reset
        ST_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == SW'(NUM_STATES - 1)) begin
            state_q <= ST_IDLE;
          end
        end

        ST_IDLE: begin
          if (in_xfer) begin
            func_q  <= in_i.func;
            from_q  <= in_idx;
            to_q    <= in_i.to_state;
            rnd_q   <= in_i.random_value;
            base_q  <= AW'(32'(in_idx) * 32'(MAX_SUCCESSORS));
            state_q <= ST_LEN;
          end
        end

        ST_LEN: begin
          len_q      <= len_rd_q;
          chk_q      <= '0;
          acc_q      <= '0;
          res_next_q <= '0;
          if (len_rd_q == '0) begin
            res_status_q <= (func_q == FUNC_RECORD) ? STATUS_OK : STATUS_EMPTY;
            state_q      <= ST_DONE;
          end else begin
            state_q <= (func_q == FUNC_RECORD) ? ST_WALK : ST_SUM;
          end
        end

        // record: search for to_state
        ST_WALK: begin
          chk_q <= chk_nx;
          if (walk_hit) begin
            res_status_q <= STATUS_OK;
            state_q      <= ST_DONE;
          end else if (walk_last) begin
            res_status_q <= append_now ? STATUS_OK : STATUS_FULL;
            state_q      <= ST_DONE;
          end
        end

        // sample: total of all counts
        ST_SUM: begin
          chk_q <= chk_nx;
          acc_q <= acc_nx;
          if (walk_last) begin
            sum_q     <= acc_nx;
            rem_q     <= '0;
            div_cnt_q <= '0;
            state_q   <= ST_DIV;
          end
        end

        // random_value modulo sum, one bit per cycle
        ST_DIV: begin
          rem_q     <= (rem_sh >= sum_ext) ? SUMW'(rem_sh - sum_ext) : SUMW'(rem_sh);
          rnd_q     <= rnd_q << 1;
          div_cnt_q <= div_cnt_q + 1'b1;
          if (div_last) begin
            chk_q   <= '0;
            acc_q   <= '0;
            state_q <= ST_PICK;
          end
        end

        // roulette wheel: first entry whose running total passes the pick
        ST_PICK: begin
          chk_q <= chk_nx;
          acc_q <= acc_nx;
          if (rem_q < acc_nx) begin
            res_status_q <= STATUS_OK;
            res_next_q   <= ent_rd_q.id;
            state_q      <= ST_DONE;
          end else if (walk_last) begin
            res_status_q <= STATUS_EMPTY;
            res_next_q   <= '0;
            state_q      <= ST_DONE;
          end
        end

        // hand the result to the output register once it is free
        ST_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            out_q.status     <= res_status_q;
            out_q.next_state <= res_next_q;
            out_valid_q      <= 1'b1;
            state_q          <= ST_IDLE;
          end
        end

        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_len_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LEN) |-> (len_rd_q <= LW'(MAX_SUCCESSORS)))
    else $error("list length above capacity");

  a_walk_in_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK || state_q == ST_SUM || state_q == ST_PICK) |-> (chk_q < len_q))
    else $error("walk index past list end");

  a_pick_below_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PICK) |-> (rem_q < sum_q))
    else $error("reduced draw not below count total");

  a_pick_hits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PICK && walk_last) |-> (rem_q < acc_nx))
    else $error("roulette walk ended without a hit");

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DONE))
    else $error("result loaded outside completion");

endmodule
